// ===== hw/rtl/ktc_pkg.sv =====
// ----------------------------------------------------------------------------
// ktc_pkg
// Shared types and constants for the kitchen timer controller.
// ----------------------------------------------------------------------------
package ktc_pkg;

  // highest minutes value shown, time saturates at this value and 59 s
  localparam logic [6:0] MINUTE_LIMIT = 7'd99;

  localparam logic [5:0] SECONDS_MAX = 6'd59;

  typedef enum logic [2:0] {
    MODE_NONE    = 3'd0,
    MODE_SET     = 3'd1,
    MODE_STOPPED = 3'd2,
    MODE_UP      = 3'd3,
    MODE_DOWN    = 3'd4,
    MODE_ALARM   = 3'd5
  } mode_t;

  // button codes
  localparam logic [2:0] BTN_START_STOP = 3'd0;
  localparam logic [2:0] BTN_RESET      = 3'd1;
  localparam logic [2:0] BTN_ADD_1S     = 3'd2;
  localparam logic [2:0] BTN_ADD_10S    = 3'd3;
  localparam logic [2:0] BTN_ADD_1M     = 3'd4;
  localparam logic [2:0] BTN_ADD_10M    = 3'd5;
  localparam logic [2:0] BTN_PRESET_ONE = 3'd6;
  localparam logic [2:0] BTN_PRESET_TWO = 3'd7;

  // action codes
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_PRESS = 1'b1;

  // configuration register indexes
  localparam logic CFG_PRESET_ONE = 1'b0;
  localparam logic CFG_PRESET_TWO = 1'b1;

  typedef struct packed {
    mode_t      mode;
    mode_t      saved;
    logic [6:0] minutes;
    logic [5:0] seconds;
  } timer_state_t;

endpackage

// ===== hw/rtl/ktc_time_add.sv =====
// ----------------------------------------------------------------------------
// ktc_time_add
// Adds minutes and seconds to a time value, carries seconds into minutes and
// saturates at the minute limit with 59 seconds.
// ----------------------------------------------------------------------------
module ktc_time_add
  import ktc_pkg::*;
(
  input  logic [6:0] minutes,
  input  logic [5:0] seconds,
  input  logic [6:0] add_minutes,
  input  logic [5:0] add_seconds,
  output logic [6:0] sum_minutes,
  output logic [5:0] sum_seconds
);

  logic [6:0] sec_sum;
  logic       carry;
  logic [6:0] sec_wrap;
  logic [7:0] min_sum;
  logic       saturate;

  // seconds stay below 60 and an add is at most 10 s, so one carry at most
  assign sec_sum  = {1'b0, seconds} + {1'b0, add_seconds};
  assign carry    = (sec_sum >= 7'd60);
  assign sec_wrap = carry ? (sec_sum - 7'd60) : sec_sum;
  assign min_sum  = {1'b0, minutes} + {1'b0, add_minutes} + {7'd0, carry};
  assign saturate = (min_sum > {1'b0, MINUTE_LIMIT});

  assign sum_minutes = saturate ? MINUTE_LIMIT : min_sum[6:0];
  assign sum_seconds = saturate ? SECONDS_MAX : sec_wrap[5:0];

endmodule

// ===== hw/rtl/ktc_next.sv =====
// ----------------------------------------------------------------------------
// ktc_next
// Next-state logic of the timer: applies one tick or one button press to the
// current mode and time.
// ----------------------------------------------------------------------------
module ktc_next
  import ktc_pkg::*;
(
  input  timer_state_t cur,
  input  logic         action,
  input  logic [2:0]   button,
  input  logic [6:0]   preset_one,
  input  logic [6:0]   preset_two,
  output timer_state_t nxt
);

  logic [6:0]   add_minutes;
  logic [5:0]   add_seconds;
  logic [6:0]   sum_minutes;
  logic [5:0]   sum_seconds;
  logic [6:0]   preset_sel;
  logic [6:0]   preset_sat;
  logic         editable;
  timer_state_t upd;

  ktc_time_add u_add (
    .minutes     (cur.minutes),
    .seconds     (cur.seconds),
    .add_minutes (add_minutes),
    .add_seconds (add_seconds),
    .sum_minutes (sum_minutes),
    .sum_seconds (sum_seconds)
  );

  assign editable   = (cur.mode inside {MODE_NONE, MODE_SET});
  assign preset_sel = (button == BTN_PRESET_ONE) ? preset_one : preset_two;
  assign preset_sat = (preset_sel > MINUTE_LIMIT) ? MINUTE_LIMIT : preset_sel;

  // amount fed to the shared adder
  always_comb begin
    add_minutes = 7'd0;
    add_seconds = 6'd0;
    if (action == ACT_TICK) begin
      add_seconds = 6'd1;
    end else begin
      case (button)
        BTN_ADD_1S:  add_seconds = 6'd1;
        BTN_ADD_10S: add_seconds = 6'd10;
        BTN_ADD_1M:  add_minutes = 7'd1;
        BTN_ADD_10M: add_minutes = 7'd10;
        default: begin
          add_minutes = 7'd0;
          add_seconds = 6'd0;
        end
      endcase
    end
  end

  always_comb begin
    upd = cur;
    if (action == ACT_PRESS) begin
      case (button)
        BTN_START_STOP: begin
          case (cur.mode)
            MODE_NONE: upd.mode = MODE_UP;
            MODE_SET:  upd.mode = MODE_DOWN;
            MODE_UP, MODE_DOWN: begin
              upd.saved = cur.mode;
              upd.mode  = MODE_STOPPED;
            end
            MODE_STOPPED: upd.mode = cur.saved;
            default: upd.mode = cur.mode;
          endcase
        end
        BTN_RESET: begin
          upd.mode    = MODE_NONE;
          upd.minutes = 7'd0;
          upd.seconds = 6'd0;
        end
        BTN_ADD_1S, BTN_ADD_10S, BTN_ADD_1M, BTN_ADD_10M: begin
          if (editable) begin
            upd.minutes = sum_minutes;
            upd.seconds = sum_seconds;
            upd.mode    = MODE_SET;
          end
        end
        default: begin
          // presets
          if (editable) begin
            upd.minutes = preset_sat;
            upd.seconds = 6'd0;
            upd.mode    = MODE_SET;
          end
        end
      endcase
    end else begin
      if (cur.mode == MODE_UP) begin
        upd.minutes = sum_minutes;
        upd.seconds = sum_seconds;
      end else if (cur.mode == MODE_DOWN) begin
        if (cur.minutes == 7'd0 && cur.seconds == 6'd0) begin
          upd.mode = MODE_ALARM;
        end else if (cur.seconds == 6'd0) begin
          upd.minutes = cur.minutes - 7'd1;
          upd.seconds = SECONDS_MAX;
        end else begin
          upd.seconds = cur.seconds - 6'd1;
        end
      end
    end

    nxt = upd;
    // a countdown sitting at zero alarms right away
    if (upd.mode == MODE_DOWN && upd.minutes == 7'd0 && upd.seconds == 6'd0) begin
      nxt.mode = MODE_ALARM;
    end
  end

endmodule

// ===== hw/rtl/kitchen_timer_controller.sv =====
// ----------------------------------------------------------------------------
// kitchen_timer_controller
// Kitchen timer with count up, countdown, presets and alarm, driven by
// one-second ticks and button press transactions.
// ----------------------------------------------------------------------------
//  channel   direction  width  contents
//  s_axis    in         8+1    tdata: button; tuser: action
//  m_axis    out        24     tdata: minutes, seconds, mode, alarm
//  cfg       in         1+7    preset minutes, index 0 first, 1 second
//
// one transaction accepted per cycle unless the output stalls; a result passes
// the input register, then the result register (timer state updates between them)
// rst is synchronous: mode none set, time 0:00, presets 3 and 5 minutes
// a stalled output holds its result; input keeps flowing while the output
// register is free or being drained the same cycle
// ----------------------------------------------------------------------------
module kitchen_timer_controller
  import ktc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [2:0] button, [7:3] zero
  input  logic        s_tuser,   // [0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [6:0] minutes_shown, [12:7] seconds_shown,
                                 // [15:13] mode_now, [16] alarm_on, [23:17] zero
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);

  logic         in_valid;
  logic         in_action;
  logic [2:0]   in_button;
  logic         advance;
  logic [6:0]   preset_one;
  logic [6:0]   preset_two;
  timer_state_t state;
  timer_state_t state_next;
  logic [6:0]   out_minutes;
  logic [5:0]   out_seconds;
  mode_t        out_mode;
  logic         out_alarm;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  ktc_next u_next (
    .cur        (state),
    .action     (in_action),
    .button     (in_button),
    .preset_one (preset_one),
    .preset_two (preset_two),
    .nxt        (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      preset_one <= 7'd3;
      preset_two <= 7'd5;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_PRESET_ONE) begin
        preset_one <= cfg_data;
      end else begin
        preset_two <= cfg_data;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_action <= s_tuser;
      in_button <= s_tdata[2:0];
    end
  end

  // timer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode    <= MODE_NONE;
      state.saved   <= MODE_NONE;
      state.minutes <= 7'd0;
      state.seconds <= 6'd0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance) begin
      out_minutes <= state_next.minutes;
      out_seconds <= state_next.seconds;
      out_mode    <= state_next.mode;
      out_alarm   <= (state_next.mode == MODE_ALARM);
    end
  end

  assign m_tdata = {7'd0, out_alarm, out_mode, out_seconds, out_minutes};

  a_alarm_matches_mode: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_alarm == (out_mode == MODE_ALARM)))
    else $error("alarm flag disagrees with mode");

  a_seconds_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_seconds <= SECONDS_MAX && out_minutes <= MINUTE_LIMIT))
    else $error("time out of range");

  a_no_idle_countdown: assert property (@(posedge clk) disable iff (rst)
    !(state.mode == MODE_DOWN && state.minutes == 7'd0 && state.seconds == 6'd0))
    else $error("countdown held at zero without alarm");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("timer state changed without a transaction");

endmodule
